// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the conversion RTL.
// Self-contained; compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmq assertion failed");
`define RMQ_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rmq reset assertion failed");
`else
`define RMQ_ASSERT(lbl, clk, rst_n, prop)
`define RMQ_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/rmq_pkg.sv =====
// Shared types and defaults for the rotation matrix to quaternion block.
// No dependencies.
`default_nettype none
package rmq_pkg;
  localparam int unsigned DataWidthDef = 18;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2,
    SEL_Z = 2'd3
  } rmq_sel_e;

  typedef struct packed {
    rmq_sel_e sel;
    logic     invalid;
  } rmq_ctrl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter.
// Uses rmq_pkg, rmq_front, rmq_fifo and rmq_back.
//
//  channel | signals                               | dir
//  in      | in_valid_i in_ready_o e11_i .. e33_i  | item in
//  out     | out_valid_o out_ready_i quat_*_o       | item out
//            invalid_o
//
// One item per cycle sustained while the output is not stalled. The back end has
// NS = ceil((SW-1+FRAC_BITS)/2) square root stages and QW = DATA_WIDTH+FRAC_BITS+2
// divider stages. A stalled output freezes the back end;
// the two-entry queue and the front register keep taking items until full.
// Reset clears valid bits and the queue pointers and count only; no clearing pass.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int unsigned DATA_WIDTH = rmq_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = rmq_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] e11_i,
  input  logic signed [DATA_WIDTH-1:0] e12_i,
  input  logic signed [DATA_WIDTH-1:0] e13_i,
  input  logic signed [DATA_WIDTH-1:0] e21_i,
  input  logic signed [DATA_WIDTH-1:0] e22_i,
  input  logic signed [DATA_WIDTH-1:0] e23_i,
  input  logic signed [DATA_WIDTH-1:0] e31_i,
  input  logic signed [DATA_WIDTH-1:0] e32_i,
  input  logic signed [DATA_WIDTH-1:0] e33_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] quat_x_o,
  output logic signed [DATA_WIDTH-1:0] quat_y_o,
  output logic signed [DATA_WIDTH-1:0] quat_z_o,
  output logic signed [DATA_WIDTH-1:0] quat_w_o,
  output logic                         invalid_o
);
  import rmq_pkg::*;

  localparam int unsigned SW = ((DATA_WIDTH + 2 > FRAC_BITS + 1) ? DATA_WIDTH + 2
                               : FRAC_BITS + 1) + 1;
  localparam int unsigned PW = DATA_WIDTH + 1;
  localparam int unsigned CT = $bits(rmq_ctrl_t);
  localparam int unsigned QD = CT + SW + 3 * PW;

  logic                 f_valid, f_ready, b_valid, b_ready;
  rmq_ctrl_t            f_ctrl, b_ctrl;
  logic signed [SW-1:0] f_s, b_s;
  logic signed [PW-1:0] f_pa, f_pb, f_pc, b_pa, b_pb, b_pc;
  logic [QD-1:0]        q_in, q_out;

  rmq_front #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .e11_i, .e12_i, .e13_i, .e21_i, .e22_i, .e23_i, .e31_i, .e32_i, .e33_i,
    .valid_o(f_valid), .ready_i(f_ready),
    .ctrl_o(f_ctrl), .s_o(f_s), .pa_o(f_pa), .pb_o(f_pb), .pc_o(f_pc)
  );

  assign q_in = {f_ctrl, f_s, f_pa, f_pb, f_pc};

  rmq_fifo #(.WIDTH(QD), .DEPTH(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(f_ready), .data_i(q_in),
    .valid_o(b_valid), .ready_i(b_ready), .data_o(q_out)
  );

  assign {b_ctrl, b_s, b_pa, b_pb, b_pc} = q_out;

  rmq_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i(b_valid), .ready_o(b_ready),
    .ctrl_i(b_ctrl), .s_i(b_s), .pa_i(b_pa), .pb_i(b_pb), .pc_i(b_pc),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .quat_x_o, .quat_y_o, .quat_z_o, .quat_w_o, .invalid_o
  );
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_front.sv =====
// Front end: forms the four diagonal terms, picks the largest, builds s and
// the three off-diagonal pairs. Depends on rmq_pkg.
`default_nettype none
module rmq_front #(
  parameter int unsigned DW = rmq_pkg::DataWidthDef,
  parameter int unsigned FB = rmq_pkg::FracBitsDef,
  localparam int unsigned TW = DW + 2,
  localparam int unsigned SW = ((DW + 2 > FB + 1) ? DW + 2 : FB + 1) + 1,
  localparam int unsigned PW = DW + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic signed [DW-1:0]  e11_i,
  input  logic signed [DW-1:0]  e12_i,
  input  logic signed [DW-1:0]  e13_i,
  input  logic signed [DW-1:0]  e21_i,
  input  logic signed [DW-1:0]  e22_i,
  input  logic signed [DW-1:0]  e23_i,
  input  logic signed [DW-1:0]  e31_i,
  input  logic signed [DW-1:0]  e32_i,
  input  logic signed [DW-1:0]  e33_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output rmq_pkg::rmq_ctrl_t    ctrl_o,
  output logic signed [SW-1:0]  s_o,
  output logic signed [PW-1:0]  pa_o,
  output logic signed [PW-1:0]  pb_o,
  output logic signed [PW-1:0]  pc_o
);
  import rmq_pkg::*;

  logic signed [TW-1:0] t0, t1, t2, t3, best;
  logic signed [SW-1:0] s_d, s_q;
  rmq_sel_e             sel;
  rmq_ctrl_t            ctrl_d, ctrl_q;
  logic signed [PW-1:0] d23m, d31m, d12m, s12p, s31p, s23p;
  logic signed [PW-1:0] pa_d, pb_d, pc_d, pa_q, pb_q, pc_q;
  logic                 v_q;

  assign t0 = TW'(e11_i) + TW'(e22_i) + TW'(e33_i);
  assign t1 = TW'(e11_i) - TW'(e22_i) - TW'(e33_i);
  assign t2 = TW'(e22_i) - TW'(e11_i) - TW'(e33_i);
  assign t3 = TW'(e33_i) - TW'(e11_i) - TW'(e22_i);

  assign d23m = PW'(e23_i) - PW'(e32_i);
  assign d31m = PW'(e31_i) - PW'(e13_i);
  assign d12m = PW'(e12_i) - PW'(e21_i);
  assign s12p = PW'(e12_i) + PW'(e21_i);
  assign s31p = PW'(e31_i) + PW'(e13_i);
  assign s23p = PW'(e23_i) + PW'(e32_i);

  always_comb begin
    best = t0;
    sel  = SEL_W;
    if (t1 > best) begin
      best = t1;
      sel  = SEL_X;
    end
    if (t2 > best) begin
      best = t2;
      sel  = SEL_Y;
    end
    if (t3 > best) begin
      best = t3;
      sel  = SEL_Z;
    end
  end

  assign s_d = SW'(best) + (SW'(1) << FB);

  always_comb begin
    ctrl_d.sel     = sel;
    ctrl_d.invalid = (s_d <= 0);
    unique case (sel)
      SEL_W: begin
        pa_d = d23m;
        pb_d = d31m;
        pc_d = d12m;
      end
      SEL_X: begin
        pa_d = d23m;
        pb_d = s12p;
        pc_d = s31p;
      end
      SEL_Y: begin
        pa_d = d31m;
        pb_d = s12p;
        pc_d = s23p;
      end
      SEL_Z: begin
        pa_d = d12m;
        pb_d = s31p;
        pc_d = s23p;
      end
      default: begin
        pa_d = '0;
        pb_d = '0;
        pc_d = '0;
      end
    endcase
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q <= ctrl_d;
      s_q    <= s_d;
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      pc_q   <= pc_d;
    end
  end

  assign valid_o = v_q;
  assign ctrl_o  = ctrl_q;
  assign s_o     = s_q;
  assign pa_o    = pa_q;
  assign pb_o    = pb_q;
  assign pc_o    = pc_q;
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_fifo.sv =====
// Short item queue between front and back end.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rmq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             push, pop;

  assign ready_o = (count_q != CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `RMQ_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `RMQ_ASSERT(a_full_blocks, clk_i, rst_ni, (count_q == CW'(DEPTH)) |-> !ready_o)
  `RMQ_ASSERT(a_push_grows, clk_i, rst_ni, (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_back.sv =====
// Back end: pipelined square root, three pipelined restoring dividers,
// rounding, saturation and output register. Depends on rmq_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rmq_back #(
  parameter int unsigned DW = rmq_pkg::DataWidthDef,
  parameter int unsigned FB = rmq_pkg::FracBitsDef,
  localparam int unsigned SW = ((DW + 2 > FB + 1) ? DW + 2 : FB + 1) + 1,
  localparam int unsigned PW = DW + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  rmq_pkg::rmq_ctrl_t    ctrl_i,
  input  logic signed [SW-1:0]  s_i,
  input  logic signed [PW-1:0]  pa_i,
  input  logic signed [PW-1:0]  pb_i,
  input  logic signed [PW-1:0]  pc_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic signed [DW-1:0]  quat_x_o,
  output logic signed [DW-1:0]  quat_y_o,
  output logic signed [DW-1:0]  quat_z_o,
  output logic signed [DW-1:0]  quat_w_o,
  output logic                  invalid_o
);
  import rmq_pkg::*;

  localparam int unsigned R   = SW - 1 + FB;
  localparam int unsigned RS  = R + (R % 2);
  localparam int unsigned NS  = RS / 2;
  localparam int unsigned RMW = NS + 3;
  localparam int unsigned DN  = NS + 2;
  localparam int unsigned QW  = PW + FB + 1;
  localparam logic [DW-1:0] MaxV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MinV = {1'b1, {(DW-1){1'b0}}};

  logic en;

  // square root stages
  logic                 sq_v_q    [NS+1];
  rmq_ctrl_t            sq_ctrl_q [NS+1];
  logic [RS-1:0]        sq_rad_q  [NS+1];
  logic [RMW-1:0]       sq_rem_q  [NS+1];
  logic [NS-1:0]        sq_root_q [NS+1];
  logic signed [PW-1:0] sq_p_q    [NS+1][3];

  // divider stages, index 0 is the prep stage
  logic                 dv_v_q    [QW+1];
  rmq_ctrl_t            dv_ctrl_q [QW+1];
  logic [NS-1:0]        dv_big_q  [QW+1];
  logic [DN-1:0]        dv_den_q  [QW+1];
  logic [QW-1:0]        dv_num_q  [QW+1][3];
  logic [DN-1:0]        dv_rem_q  [QW+1][3];
  logic                 dv_neg_q  [QW+1][3];

  logic                 out_v_q, out_inv_q;
  rmq_sel_e             out_sel_q;
  logic signed [DW-1:0] out_x_q, out_y_q, out_z_q, out_w_q;
  logic                 out_zero, out_stall;

  assign en      = !out_v_q || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_ctrl_q[0] <= ctrl_i;
      sq_rad_q[0]  <= ctrl_i.invalid ? '0 : (RS'(s_i[SW-2:0]) << FB);
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_p_q[0][0] <= pa_i;
      sq_p_q[0][1] <= pb_i;
      sq_p_q[0][2] <= pc_i;
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_sqrt
    logic [RMW-1:0] cur, trial;
    logic           ge;
    assign cur   = {sq_rem_q[j-1][RMW-3:0], sq_rad_q[j-1][RS-1 -: 2]};
    assign trial = {1'b0, sq_root_q[j-1], 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[j] <= 1'b0;
      end else if (en) begin
        sq_v_q[j] <= sq_v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_ctrl_q[j] <= sq_ctrl_q[j-1];
        sq_rad_q[j]  <= sq_rad_q[j-1] << 2;
        sq_rem_q[j]  <= ge ? cur - trial : cur;
        sq_root_q[j] <= {sq_root_q[j-1][NS-2:0], ge};
        sq_p_q[j]    <= sq_p_q[j-1];
      end
    end
  end

  // prep: big, denominator, numerators
  logic [NS-1:0] big;
  assign big = NS'(({1'b0, sq_root_q[NS]} + 1'b1) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[NS];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_prep
    logic          neg;
    logic [PW-1:0] mag;
    assign neg = sq_p_q[NS][l][PW-1];
    assign mag = neg ? PW'(~sq_p_q[NS][l] + 1'b1) : PW'(sq_p_q[NS][l]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_num_q[0][l] <= (QW'(mag) << FB) + QW'({big, 1'b0});
        dv_rem_q[0][l] <= '0;
        dv_neg_q[0][l] <= neg;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_ctrl_q[0] <= sq_ctrl_q[NS];
      dv_big_q[0]  <= big;
      dv_den_q[0]  <= {big, 2'b00};
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else if (en) begin
        dv_v_q[k] <= dv_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_ctrl_q[k] <= dv_ctrl_q[k-1];
        dv_big_q[k]  <= dv_big_q[k-1];
        dv_den_q[k]  <= dv_den_q[k-1];
        dv_neg_q[k]  <= dv_neg_q[k-1];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DN:0] cur;
      logic        ge;
      assign cur = {dv_rem_q[k-1][l], dv_num_q[k-1][l][QW-1]};
      assign ge  = (cur >= {1'b0, dv_den_q[k-1]});
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_rem_q[k][l] <= ge ? DN'(cur - {1'b0, dv_den_q[k-1]}) : DN'(cur);
          dv_num_q[k][l] <= {dv_num_q[k-1][l][QW-2:0], ge};
        end
      end
    end
  end

  function automatic logic [DW-1:0] sat_q(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] nq;
    nq = ~q + 1'b1;
    if (neg) begin
      sat_q = (q > QW'(MinV)) ? MinV : nq[DW-1:0];
    end else begin
      sat_q = (q > QW'(MaxV)) ? MaxV : q[DW-1:0];
    end
  endfunction

  logic [DW-1:0] qa, qb, qc, qbig;
  assign qa   = sat_q(dv_num_q[QW][0], dv_neg_q[QW][0]);
  assign qb   = sat_q(dv_num_q[QW][1], dv_neg_q[QW][1]);
  assign qc   = sat_q(dv_num_q[QW][2], dv_neg_q[QW][2]);
  assign qbig = ((QW + NS)'(dv_big_q[QW]) > (QW + NS)'(MaxV)) ? MaxV
              : DW'(dv_big_q[QW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_inv_q <= dv_ctrl_q[QW].invalid;
      out_sel_q <= dv_ctrl_q[QW].sel;
      if (dv_ctrl_q[QW].invalid) begin
        out_x_q <= '0;
        out_y_q <= '0;
        out_z_q <= '0;
        out_w_q <= '0;
      end else begin
        unique case (dv_ctrl_q[QW].sel)
          SEL_W: begin
            out_w_q <= qbig; out_x_q <= qa; out_y_q <= qb; out_z_q <= qc;
          end
          SEL_X: begin
            out_x_q <= qbig; out_w_q <= qa; out_y_q <= qb; out_z_q <= qc;
          end
          SEL_Y: begin
            out_y_q <= qbig; out_w_q <= qa; out_x_q <= qb; out_z_q <= qc;
          end
          SEL_Z: begin
            out_z_q <= qbig; out_w_q <= qa; out_x_q <= qb; out_y_q <= qc;
          end
          default: begin
            out_x_q <= '0; out_y_q <= '0; out_z_q <= '0; out_w_q <= '0;
          end
        endcase
      end
    end
  end

  assign valid_o   = out_v_q;
  assign invalid_o = out_inv_q;
  assign quat_x_o  = out_x_q;
  assign quat_y_o  = out_y_q;
  assign quat_z_o  = out_z_q;
  assign quat_w_o  = out_w_q;

  assign out_zero  = (out_x_q == '0) && (out_y_q == '0) && (out_z_q == '0) && (out_w_q == '0);
  assign out_stall = out_v_q && !ready_i;

  `RMQ_ASSERT(a_inv_zero, clk_i, rst_ni, (out_v_q && out_inv_q) |-> out_zero)
  `RMQ_ASSERT(a_big_w_pos, clk_i, rst_ni, (out_v_q && !out_inv_q && out_sel_q == SEL_W) |-> !out_w_q[DW-1])
  `RMQ_ASSERT(a_stall_hold, clk_i, rst_ni, out_stall |=> (out_v_q && $stable(out_x_q) && $stable(out_w_q)))
  `RMQ_ASSERT_RST(a_reset_idle, clk_i, !rst_ni |=> !out_v_q)
endmodule
`default_nettype wire

// ===== verif/tb_rotation_matrix_to_quaternion.sv =====
// Self-checking testbench for rotation_matrix_to_quaternion.
// Drives matrices through a valid/ready driver, predicts each quaternion in place,
// and checks results from a monitor. Depends on rmq_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int DW = DataWidthDef;
  localparam int FB = FracBitsDef;
  localparam longint MaxV = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint MinV = -(64'sd1 <<< (DW - 1));
  localparam int StallLimit = 4000;

  typedef struct {
    logic [DW-1:0] e [9];
  } matrix_t;

  typedef struct {
    logic [DW-1:0] x, y, z, w;
    logic          inv;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, invalid_o;
  logic signed [DW-1:0] e11_i = '0, e12_i = '0, e13_i = '0, e21_i = '0, e22_i = '0;
  logic signed [DW-1:0] e23_i = '0, e31_i = '0, e32_i = '0, e33_i = '0;
  logic signed [DW-1:0] quat_x_o, quat_y_o, quat_z_o, quat_w_o;

  matrix_t matrix_q[$];
  quat_t   quat_q[$];
  matrix_t cur;
  int      n_acc = 0;
  int      n_err = 0;
  int      idle_cnt = 0;
  bit      stim_done = 0;

  rotation_matrix_to_quaternion dut (.*);

  initial forever #2 clk_i = ~clk_i;

  function automatic longint sx(logic [DW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint sat(longint v);
    if (v > MaxV) return MaxV;
    if (v < MinV) return MinV;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [DW-1:0] scaled_ratio(longint p, longint unsigned den);
    longint unsigned mag, q;
    mag = (p < 0) ? longint'(-p) : longint'(p);
    if (den == 0) return '0;
    q = ((mag << FB) + (den >> 1)) / den;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return DW'(sat((p < 0) ? -longint'(q) : longint'(q)));
  endfunction

  function automatic quat_t to_quat(matrix_t m);
    quat_t r;
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33, best, s;
    longint t [4];
    longint unsigned big, den;
    rmq_sel_e sel;
    a11 = sx(m.e[0]); a12 = sx(m.e[1]); a13 = sx(m.e[2]);
    a21 = sx(m.e[3]); a22 = sx(m.e[4]); a23 = sx(m.e[5]);
    a31 = sx(m.e[6]); a32 = sx(m.e[7]); a33 = sx(m.e[8]);
    t[0] = a11 + a22 + a33;
    t[1] = a11 - a22 - a33;
    t[2] = a22 - a11 - a33;
    t[3] = a33 - a11 - a22;
    best = t[0];
    sel = SEL_W;
    for (int i = 1; i < 4; i++) begin
      if (t[i] > best) begin
        best = t[i];
        sel = rmq_sel_e'(i);
      end
    end
    s = best + (64'sd1 <<< FB);
    r = '{x: '0, y: '0, z: '0, w: '0, inv: 1'b0};
    if (s <= 0) begin
      r.inv = 1'b1;
      return r;
    end
    big = (int_sqrt(longint'(s) << FB) + 1) >> 1;
    den = big << 2;
    case (sel)
      SEL_W: begin
        r.w = DW'(sat(longint'(big)));
        r.x = scaled_ratio(a23 - a32, den);
        r.y = scaled_ratio(a31 - a13, den);
        r.z = scaled_ratio(a12 - a21, den);
      end
      SEL_X: begin
        r.x = DW'(sat(longint'(big)));
        r.w = scaled_ratio(a23 - a32, den);
        r.y = scaled_ratio(a12 + a21, den);
        r.z = scaled_ratio(a31 + a13, den);
      end
      SEL_Y: begin
        r.y = DW'(sat(longint'(big)));
        r.w = scaled_ratio(a31 - a13, den);
        r.x = scaled_ratio(a12 + a21, den);
        r.z = scaled_ratio(a23 + a32, den);
      end
      default: begin
        r.z = DW'(sat(longint'(big)));
        r.w = scaled_ratio(a12 - a21, den);
        r.x = scaled_ratio(a31 + a13, den);
        r.y = scaled_ratio(a23 + a32, den);
      end
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [DW-1:0] got, logic [DW-1:0] exp_v);
    n_err++;
    $display("mismatch item %0d %s: got %0d exp %0d", n_acc, what,
             signed'(got), signed'(exp_v));
  endtask

  function automatic logic [DW-1:0] to_fix(real v);
    longint f;
    f = longint'($rtoi(v * (2.0 ** FB)));
    return DW'(sat(f));
  endfunction

  function automatic matrix_t rotation();
    matrix_t m;
    real qx, qy, qz, qw, n;
    qx = real'($urandom_range(2000)) - 1000.0;
    qy = real'($urandom_range(2000)) - 1000.0;
    qz = real'($urandom_range(2000)) - 1000.0;
    qw = real'($urandom_range(2000)) - 1000.0;
    n = $sqrt(qx * qx + qy * qy + qz * qz + qw * qw);
    if (n < 1.0) begin
      qw = 1.0;
      n = 1.0;
    end
    qx = qx / n; qy = qy / n; qz = qz / n; qw = qw / n;
    m.e[0] = to_fix(1.0 - 2.0 * (qy * qy + qz * qz));
    m.e[1] = to_fix(2.0 * (qx * qy - qz * qw));
    m.e[2] = to_fix(2.0 * (qx * qz + qy * qw));
    m.e[3] = to_fix(2.0 * (qx * qy + qz * qw));
    m.e[4] = to_fix(1.0 - 2.0 * (qx * qx + qz * qz));
    m.e[5] = to_fix(2.0 * (qy * qz - qx * qw));
    m.e[6] = to_fix(2.0 * (qx * qz - qy * qw));
    m.e[7] = to_fix(2.0 * (qy * qz + qx * qw));
    m.e[8] = to_fix(1.0 - 2.0 * (qx * qx + qy * qy));
    return m;
  endfunction

  function automatic matrix_t diag(longint d1, longint d2, longint d3, longint off);
    matrix_t m;
    foreach (m.e[i]) m.e[i] = DW'(off);
    m.e[0] = DW'(d1);
    m.e[4] = DW'(d2);
    m.e[8] = DW'(d3);
    return m;
  endfunction

  initial begin
    matrix_t m;
    longint one;
    one = 64'sd1 <<< FB;
    // directed: identity, each dominant diagonal, ties, extremes, saturation
    matrix_q.push_back(diag(one, one, one, 0));
    matrix_q.push_back(diag(one, -one, -one, 0));
    matrix_q.push_back(diag(-one, one, -one, 0));
    matrix_q.push_back(diag(-one, -one, one, 0));
    matrix_q.push_back(diag(0, 0, 0, 0));
    matrix_q.push_back(diag(one, one, -one, 0));
    matrix_q.push_back(diag(-one, -one, -one, 0));
    matrix_q.push_back(diag(MaxV, MaxV, MaxV, MaxV));
    matrix_q.push_back(diag(MinV, MinV, MinV, MinV));
    matrix_q.push_back(diag(MaxV, MinV, MinV, MaxV));
    matrix_q.push_back(diag(MinV, MaxV, MinV, MinV));
    matrix_q.push_back(diag(MinV, MinV, MaxV, MaxV));
    matrix_q.push_back(diag(0, 0, 0, MaxV));
    matrix_q.push_back(diag(0, 0, 0, MinV));
    m = diag(0, 0, 0, 0);
    m.e[5] = DW'(MaxV); m.e[7] = DW'(MinV);
    m.e[6] = DW'(MaxV); m.e[2] = DW'(MinV);
    m.e[1] = DW'(MaxV); m.e[3] = DW'(MinV);
    matrix_q.push_back(m);
    m.e[5] = DW'(MinV); m.e[7] = DW'(MaxV);
    m.e[6] = DW'(MinV); m.e[2] = DW'(MaxV);
    m.e[1] = DW'(MinV); m.e[3] = DW'(MaxV);
    matrix_q.push_back(m);
    matrix_q.push_back(diag(1, 1, 1, 1));
    matrix_q.push_back(diag(-1, -1, -1, -1));
    matrix_q.push_back(diag(-one + 1, -one + 1, -one + 1, 3));
    repeat (530) begin
      case ($urandom_range(99) / 20)
        0, 1, 2: m = rotation();
        3: foreach (m.e[i]) m.e[i] = DW'($urandom);
        default: begin
          m = rotation();
          m.e[$urandom_range(8)] = ($urandom_range(1)) ? DW'(MaxV) : DW'(MinV);
          m.e[$urandom_range(8)] = DW'($urandom);
        end
      endcase
      matrix_q.push_back(m);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (matrix_q.size() == 0 && !in_valid_i);
    wait (quat_q.size() == 0);
    repeat (100) @(posedge clk_i);
    stim_done = 1;
    if (n_err == 0 && quat_q.size() == 0) begin
      $display("rotation_matrix_to_quaternion verification clean");
    end else begin
      $display("rotation_matrix_to_quaternion verification failed");
    end
    $finish;
  end

  // driver; idle odds follow the accepted count
  always @(posedge clk_i) begin
    int send_idle;
    send_idle = (n_acc < 180) ? 35 : (n_acc < 360) ? 88 : 0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        quat_q.push_back(to_quat(cur));
        n_acc++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (matrix_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur = matrix_q.pop_front();
          e11_i <= cur.e[0]; e12_i <= cur.e[1]; e13_i <= cur.e[2];
          e21_i <= cur.e[3]; e22_i <= cur.e[4]; e23_i <= cur.e[5];
          e31_i <= cur.e[6]; e32_i <= cur.e[7]; e33_i <= cur.e[8];
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i) begin
    int recv_idle;
    quat_t q;
    recv_idle = (n_acc < 180) ? 88 : (n_acc < 360) ? 35 : 0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (quat_q.size() == 0) begin
          n_err++;
          $display("unexpected quaternion at item count %0d", n_acc);
        end else begin
          q = quat_q.pop_front();
          if (quat_x_o !== q.x) report("quat_x", quat_x_o, q.x);
          if (quat_y_o !== q.y) report("quat_y", quat_y_o, q.y);
          if (quat_z_o !== q.z) report("quat_z", quat_z_o, q.z);
          if (quat_w_o !== q.w) report("quat_w", quat_w_o, q.w);
          if (invalid_o !== q.inv) report("invalid", DW'(invalid_o), DW'(q.inv));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= StallLimit && !stim_done) begin
      $display("rotation_matrix_to_quaternion verification failed");
      $finish;
    end
  end
endmodule
